// ===== hw/rtl/c8ie_pkg.sv =====
// package: shared types, constants and font table for the chip-8 execute core
package c8ie_pkg;

	localparam int MEM_BYTES     = 4096;
	localparam int STACK_ENTRIES = 16;
	localparam int SCREEN_HEIGHT = 32;
	localparam int PROGRAM_BASE  = 512;
	localparam int FONT_BASE     = 80;
	localparam int SP_W          = $clog2(STACK_ENTRIES + 1);
	localparam int SI_W          = $clog2(STACK_ENTRIES);

	localparam logic [1:0] ACT_EXEC = 2'd0;
	localparam logic [1:0] ACT_LOAD = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	localparam logic [1:0] FAULT_NONE  = 2'd0;
	localparam logic [1:0] FAULT_UNDER = 2'd1;
	localparam logic [1:0] FAULT_OVER  = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [11:0] load_address;
		logic [7:0]  load_data;
		logic [4:0]  row_select;
		logic [15:0] keys_pressed;
		logic [7:0]  random_byte;
	} in_word_t;

	typedef struct packed {
		logic [11:0] next_pc;
		logic [7:0]  delay_value;
		logic [7:0]  sound_value;
		logic [1:0]  fault_code;
		logic        waiting_key;
		logic        drew;
		logic [63:0] row_pixels;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_INIT, ST_FETCH_HI, ST_FETCH_LO, ST_DECODE, ST_EXEC,
		ST_CLEAR, ST_DRAW_RD, ST_DRAW_WR, ST_BCD, ST_STORE, ST_LOAD_RD,
		ST_LOAD_WR, ST_ROW_RD, ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE, CMD_INIT, CMD_FETCH_HI, CMD_FETCH_LO, CMD_DECODE, CMD_EXEC,
		CMD_CLEAR, CMD_DRAW_RD, CMD_DRAW_WR, CMD_BCD, CMD_STORE, CMD_LOAD_RD,
		CMD_LOAD_WR, CMD_ROW_RD, CMD_START
	} cmd_t;

	typedef struct packed {
		logic is_clear;
		logic is_draw;
		logic is_bcd;
		logic is_store;
		logic is_load;
		logic halted;
		logic is_exec;
		logic last;
	} status_t;

	function automatic logic [7:0] font_byte(input logic [6:0] i);
		logic [7:0] f [80];
		f = '{8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
		      8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
		      8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
		      8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
		      8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
		      8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
		      8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
		      8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};
		return (i < 7'd80) ? f[i] : 8'h00;
	endfunction

endpackage

// ===== hw/rtl/c8ie_ctrl.sv =====
// controller: sequences fetch, execute and the serial memory and screen walks
module c8ie_ctrl import c8ie_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    out_busy,
	input  status_t status,
	output cmd_t    cmd,
	output logic    in_take,
	output logic    out_set
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_INIT;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = CMD_NONE;
		in_take = 1'b0;
		out_set = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cmd = CMD_INIT;
				if (status.last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					in_take = 1'b1;
					cmd = CMD_START;
					if (status.is_exec && !status.halted) state_d = ST_FETCH_HI;
					else state_d = ST_ROW_RD;
				end
			end
			ST_FETCH_HI: begin cmd = CMD_FETCH_HI; state_d = ST_FETCH_LO; end
			ST_FETCH_LO: begin cmd = CMD_FETCH_LO; state_d = ST_DECODE; end
			ST_DECODE: begin cmd = CMD_DECODE; state_d = ST_EXEC; end
			ST_EXEC: begin
				cmd = CMD_EXEC;
				if (status.is_clear) state_d = ST_CLEAR;
				else if (status.is_draw) state_d = ST_DRAW_RD;
				else if (status.is_bcd) state_d = ST_BCD;
				else if (status.is_store) state_d = ST_STORE;
				else if (status.is_load) state_d = ST_LOAD_RD;
				else state_d = ST_ROW_RD;
			end
			ST_CLEAR: begin
				cmd = CMD_CLEAR;
				if (status.last) state_d = ST_ROW_RD;
			end
			ST_DRAW_RD: begin
				cmd = CMD_DRAW_RD;
				state_d = status.last ? ST_ROW_RD : ST_DRAW_WR;
			end
			ST_DRAW_WR: begin cmd = CMD_DRAW_WR; state_d = ST_DRAW_RD; end
			ST_BCD: begin
				cmd = CMD_BCD;
				if (status.last) state_d = ST_ROW_RD;
			end
			ST_STORE: begin
				cmd = CMD_STORE;
				if (status.last) state_d = ST_ROW_RD;
			end
			ST_LOAD_RD: begin cmd = CMD_LOAD_RD; state_d = ST_LOAD_WR; end
			ST_LOAD_WR: begin
				cmd = CMD_LOAD_WR;
				state_d = status.last ? ST_ROW_RD : ST_LOAD_RD;
			end
			ST_ROW_RD: begin cmd = CMD_ROW_RD; state_d = ST_DONE; end
			ST_DONE: begin
				if (!out_busy) begin
					out_set = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/c8ie_dp.sv =====
// datapath: memory, screen, registers, stack and instruction execution
module c8ie_dp import c8ie_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	input  in_word_t  in_word,
	output status_t   status,
	output out_word_t res
);

	logic [7:0]  mem [MEM_BYTES];
	logic [63:0] scr [SCREEN_HEIGHT];
	logic [7:0]  mem_rd_q;
	logic [63:0] scr_rd_q;

	logic [7:0]  v_q [16];
	logic [11:0] stk_q [STACK_ENTRIES];
	logic [SP_W-1:0] sp_q;
	logic [11:0] pc_q;
	logic [15:0] idx_q;
	logic [7:0]  dly_q, snd_q;
	logic [15:0] key_q;
	logic [1:0]  halt_q;
	in_word_t    in_q;
	logic [7:0]  hi_q, lo_q;
	logic [7:0]  vx_q, vy_q;
	logic [12:0] cnt_q;
	logic [7:0]  xs_q, ys_q;
	logic        hit_q, drew_q, wait_q;

	// memory port selection
	logic        mem_we;
	logic [11:0] mem_wa, mem_ra;
	logic [7:0]  mem_wd;
	logic        scr_we;
	logic [4:0]  scr_wa, scr_ra;
	logic [63:0] scr_wd;

	logic [3:0]  op, xi, yi, ni;
	logic [11:0] nnn;
	logic [3:0]  cnt4;
	logic [4:0]  draw_row;
	logic [127:0] spread;
	logic [63:0] mask;
	logic [7:0]  bcd_d;
	logic [7:0]  bcd_h, bcd_rem, bcd_t, bcd_o;
	logic [15:0] key_now;

	assign op  = hi_q[7:4];
	assign xi  = hi_q[3:0];
	assign yi  = lo_q[7:4];
	assign ni  = lo_q[3:0];
	assign nnn = {xi, lo_q};
	assign cnt4 = cnt_q[3:0];
	assign draw_row = ys_q[4:0] + {1'b0, cnt4};
	assign key_now = key_q | in_word.keys_pressed;

	// sprite byte placed at column xs, wrapping over 64 columns
	always_comb begin
		spread = {mem_rd_q, 120'd0} >> xs_q[5:0];
		mask = spread[127:64] | spread[63:0];
	end

	// decimal digits by compare and subtract
	always_comb begin
		if (vx_q >= 8'd200) begin
			bcd_h = 8'd2; bcd_rem = vx_q - 8'd200;
		end else if (vx_q >= 8'd100) begin
			bcd_h = 8'd1; bcd_rem = vx_q - 8'd100;
		end else begin
			bcd_h = 8'd0; bcd_rem = vx_q;
		end
		bcd_t = 8'd0;
		for (int k = 1; k < 10; k++)
			if (bcd_rem >= 8'(10 * k)) bcd_t = 8'(k);
		bcd_o = bcd_rem - {bcd_t[4:0], 3'b000} - {bcd_t[6:0], 1'b0};
		case (cnt_q[1:0])
			2'd0: bcd_d = bcd_h;
			2'd1: bcd_d = bcd_t;
			default: bcd_d = bcd_o;
		endcase
	end

	always_comb begin
		mem_we = 1'b0; mem_wa = '0; mem_wd = '0; mem_ra = pc_q;
		scr_we = 1'b0; scr_wa = '0; scr_wd = '0; scr_ra = in_q.row_select;
		case (cmd)
			CMD_INIT: begin
				mem_we = 1'b1; mem_wa = cnt_q[11:0]; mem_wd = 8'h00;
				if (cnt_q >= 13'(FONT_BASE) && cnt_q < 13'(FONT_BASE + 80))
					mem_wd = font_byte(7'(cnt_q - 13'(FONT_BASE)));
				scr_we = 1'b1; scr_wa = cnt_q[4:0];
			end
			CMD_START: begin
				mem_we = (in_word.action == ACT_LOAD);
				mem_wa = in_word.load_address; mem_wd = in_word.load_data;
			end
			CMD_FETCH_HI: mem_ra = pc_q;
			CMD_FETCH_LO: mem_ra = pc_q + 12'd1;
			CMD_CLEAR: begin scr_we = 1'b1; scr_wa = cnt_q[4:0]; end
			CMD_DRAW_RD: begin mem_ra = idx_q[11:0] + {8'd0, cnt4}; scr_ra = draw_row; end
			CMD_DRAW_WR: begin scr_we = 1'b1; scr_wa = draw_row; scr_wd = scr_rd_q ^ mask; end
			CMD_BCD: begin mem_we = 1'b1; mem_wa = idx_q[11:0] + {10'd0, cnt_q[1:0]}; mem_wd = bcd_d; end
			CMD_STORE: begin mem_we = 1'b1; mem_wa = idx_q[11:0] + {8'd0, cnt4}; mem_wd = v_q[cnt4]; end
			CMD_LOAD_RD: mem_ra = idx_q[11:0] + {8'd0, cnt4};
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		mem_rd_q <= mem[mem_ra];
		if (scr_we) scr[scr_wa] <= scr_wd;
		scr_rd_q <= scr[scr_ra];
	end

	always_comb begin
		status.is_clear = (hi_q == 8'h00 && lo_q == 8'hE0);
		status.is_draw  = (op == 4'hD);
		status.is_bcd   = (op == 4'hF && lo_q == 8'h33);
		status.is_store = (op == 4'hF && lo_q == 8'h55);
		status.is_load  = (op == 4'hF && lo_q == 8'h65);
		status.halted   = (halt_q != FAULT_NONE);
		status.is_exec  = (in_word.action == ACT_EXEC);
		case (cmd)
			CMD_INIT:    status.last = (cnt_q == 13'(MEM_BYTES - 1));
			CMD_CLEAR:   status.last = (cnt_q == 13'(SCREEN_HEIGHT - 1));
			CMD_DRAW_RD: status.last = (cnt_q[4:0] == {1'b0, ni});
			CMD_BCD:     status.last = (cnt_q[1:0] == 2'd2);
			CMD_STORE, CMD_LOAD_WR: status.last = (cnt4 == xi);
			default:     status.last = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) v_q[i] <= '0;
			for (int i = 0; i < STACK_ENTRIES; i++) stk_q[i] <= '0;
			sp_q <= '0; pc_q <= 12'(PROGRAM_BASE); idx_q <= '0;
			dly_q <= '0; snd_q <= '0; key_q <= '0; halt_q <= FAULT_NONE;
			cnt_q <= '0; drew_q <= 1'b0; wait_q <= 1'b0; hit_q <= 1'b0;
			in_q <= '0; hi_q <= '0; lo_q <= '0; vx_q <= '0; vy_q <= '0;
			xs_q <= '0; ys_q <= '0;
		end else begin
			case (cmd)
				CMD_INIT: cnt_q <= cnt_q + 13'd1;
				CMD_START: begin
					in_q <= in_word; key_q <= key_now;
					drew_q <= 1'b0; wait_q <= 1'b0; cnt_q <= '0; hit_q <= 1'b0;
				end
				CMD_FETCH_LO: hi_q <= mem_rd_q;
				CMD_DECODE: begin
					lo_q <= mem_rd_q; vx_q <= v_q[xi]; vy_q <= v_q[mem_rd_q[7:4]];
					xs_q <= v_q[xi]; ys_q <= v_q[mem_rd_q[7:4]];
				end
				CMD_EXEC: begin
					pc_q <= pc_q + 12'd2;
					unique case (op)
						4'h0: begin
							if (hi_q == 8'h00 && lo_q == 8'hEE) begin
								if (sp_q == '0) begin halt_q <= FAULT_UNDER; pc_q <= pc_q; end
								else begin
									sp_q <= sp_q - 1'b1;
									pc_q <= stk_q[SI_W'(sp_q - 1'b1)];
								end
							end
						end
						4'h1: pc_q <= nnn;
						4'h2: begin
							if (sp_q >= SP_W'(STACK_ENTRIES)) begin
								halt_q <= FAULT_OVER; pc_q <= pc_q;
							end else begin
								stk_q[SI_W'(sp_q)] <= pc_q + 12'd2;
								sp_q <= sp_q + 1'b1; pc_q <= nnn;
							end
						end
						4'h3: if (vx_q == lo_q) pc_q <= pc_q + 12'd4;
						4'h4: if (vx_q != lo_q) pc_q <= pc_q + 12'd4;
						4'h5: if (vx_q == vy_q) pc_q <= pc_q + 12'd4;
						4'h6: v_q[xi] <= lo_q;
						4'h7: v_q[xi] <= vx_q + lo_q;
						4'h8: begin
							case (ni)
								4'h0: v_q[xi] <= vy_q;
								4'h1: v_q[xi] <= vx_q | vy_q;
								4'h2: v_q[xi] <= vx_q & vy_q;
								4'h3: v_q[xi] <= vx_q ^ vy_q;
								4'h4: begin
									v_q[xi] <= vx_q + vy_q;
									v_q[15] <= {7'd0, 9'({1'b0, vx_q} + {1'b0, vy_q}) > 9'd255};
								end
								4'h5: begin v_q[xi] <= vx_q - vy_q; v_q[15] <= {7'd0, vx_q >= vy_q}; end
								4'h6: begin v_q[xi] <= vx_q >> 1; v_q[15] <= {7'd0, vx_q[0]}; end
								4'h7: begin v_q[xi] <= vy_q - vx_q; v_q[15] <= {7'd0, vy_q >= vx_q}; end
								4'hE: begin v_q[xi] <= vx_q << 1; v_q[15] <= {7'd0, vx_q[7]}; end
								default: ;
							endcase
						end
						4'h9: if (vx_q != vy_q) pc_q <= pc_q + 12'd4;
						4'hA: idx_q <= {4'd0, nnn};
						4'hB: pc_q <= nnn + {4'd0, v_q[0]};
						4'hC: v_q[xi] <= in_q.random_byte & lo_q;
						4'hD: drew_q <= 1'b1;
						4'hE: begin
							if (lo_q == 8'h9E || lo_q == 8'hA1) begin
								if (key_q[vx_q[3:0]] == (lo_q == 8'h9E)) pc_q <= pc_q + 12'd4;
								key_q <= '0;
							end
						end
						4'hF: begin
							case (lo_q)
								8'h07: v_q[xi] <= dly_q;
								8'h0A: begin
									if (key_q == '0) begin wait_q <= 1'b1; pc_q <= pc_q; end
									else begin
										for (int i = 15; i >= 0; i--)
											if (key_q[i]) v_q[xi] <= 8'(i);
									end
									key_q <= '0;
								end
								8'h15: dly_q <= vx_q;
								8'h18: snd_q <= vx_q;
								8'h1E: idx_q <= idx_q + {8'd0, vx_q};
								8'h29: idx_q <= 16'(FONT_BASE) + 16'({vx_q[3:0], 2'b00}) + {12'd0, vx_q[3:0]};
								default: ;
							endcase
						end
						default: ;
					endcase
				end
				CMD_CLEAR, CMD_BCD, CMD_STORE: cnt_q <= cnt_q + 13'd1;
				CMD_DRAW_WR: begin
					if ((scr_rd_q & mask) != '0) hit_q <= 1'b1;
					if (cnt_q[4:0] + 5'd1 == {1'b0, ni})
						v_q[15] <= {7'd0, hit_q || ((scr_rd_q & mask) != '0)};
					cnt_q <= cnt_q + 13'd1;
				end
				CMD_LOAD_WR: begin v_q[cnt4] <= mem_rd_q; cnt_q <= cnt_q + 13'd1; end
				default: ;
			endcase
			// draw with zero rows still clears the flag
			if (cmd == CMD_DRAW_RD && ni == 4'd0) v_q[15] <= 8'd0;
		end
	end

	// sprite byte read in the read step arrives on mem_rd_q in the write step
	always_comb begin
		res.next_pc     = pc_q;
		res.delay_value = dly_q;
		res.sound_value = snd_q;
		res.fault_code  = halt_q;
		res.waiting_key = wait_q;
		res.drew        = drew_q;
		res.row_pixels  = scr_rd_q;
	end

endmodule

// ===== hw/rtl/chip8_instruction_execute_top.sv =====
// top level: chip-8 execute core with valid/stall channels
// one word in, one word out. an execute word steps through fetch high, fetch
// low, decode and execute, then its walk, if any: clear screen, draw, bcd,
// register store or register load; every word ends with a row read. the walks
// are needed because memory and screen are arrays with one read and one write
// port each. after reset a clearing pass over all of memory loads the font and
// blanks the screen, and no word is taken until it ends. the result register
// holds a finished word while the next word is taken and worked on; that word
// then waits at its last step until the result register is free.
module chip8_instruction_execute_top import c8ie_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_data
);

	cmd_t      cmd;
	status_t   status;
	out_word_t res;
	logic      in_take, out_set;
	logic      out_valid_q;
	out_word_t out_q;

	c8ie_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid),
		.out_busy(out_valid_q && out_stall),
		.status(status), .cmd(cmd), .in_take(in_take), .out_set(out_set)
	);

	c8ie_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_word(in_data),
		.status(status), .res(res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_set) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_set) out_q <= res;
	end

	assign in_stall  = !in_take;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== hw/rtl/c8ie_check.sv =====
// checker: port-level properties of the execute core
module c8ie_check import c8ie_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_word_t out_data
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !(in_valid && !in_stall))
		else $error("two words taken back to back");

	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_valid |-> in_stall)
		else $error("stall released with no word offered");

	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.fault_code != 2'd3)
		else $error("bad fault code");

endmodule

bind chip8_instruction_execute_top c8ie_check u_check (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// ===== tb/c8ie_tb_pkg.sv =====
`timescale 1ns / 100ps
// package: opcode fields and action codes shared by the chip-8 testbench files
package c8ie_tb_pkg;

	import c8ie_pkg::*;

	localparam logic [1:0] ACT_NOP = 2'd3;

	typedef enum logic [3:0] {
		OP_SYS, OP_JP, OP_CALL, OP_SEQI, OP_SNEI, OP_SEQ, OP_LDI, OP_ADDI,
		OP_ALU, OP_SNE, OP_LDIDX, OP_JPV0, OP_RND, OP_DRW, OP_KEY, OP_MISC
	} op_t;

	typedef enum logic [3:0] {
		ALU_MOV = 4'h0, ALU_OR = 4'h1, ALU_AND = 4'h2, ALU_XOR = 4'h3,
		ALU_ADD = 4'h4, ALU_SUB = 4'h5, ALU_SHR = 4'h6, ALU_SUBN = 4'h7,
		ALU_SHL = 4'hE
	} alu_t;

	localparam logic [7:0] LO_CLS  = 8'hE0;
	localparam logic [7:0] LO_RET  = 8'hEE;
	localparam logic [7:0] LO_SKP  = 8'h9E;
	localparam logic [7:0] LO_SKNP = 8'hA1;
	localparam logic [7:0] LO_GDT  = 8'h07;
	localparam logic [7:0] LO_WKEY = 8'h0A;
	localparam logic [7:0] LO_SDT  = 8'h15;
	localparam logic [7:0] LO_SST  = 8'h18;
	localparam logic [7:0] LO_ADDI = 8'h1E;
	localparam logic [7:0] LO_FONT = 8'h29;
	localparam logic [7:0] LO_BCD  = 8'h33;
	localparam logic [7:0] LO_STR  = 8'h55;
	localparam logic [7:0] LO_LDR  = 8'h65;

endpackage

// ===== tb/chip8_ie_checker.sv =====
`timescale 1ns / 100ps
// checker: shadow chip-8 machine, expected word queue and field compare
module chip8_ie_checker import c8ie_pkg::*; import c8ie_tb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_word_t    in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_word_t   out_data,
	output int          errors,
	output int          pending,
	output logic [11:0] pc_now,
	output int          depth_now
);

	localparam logic [7:0] GLYPHS [80] = '{
		8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
		8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
		8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
		8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
		8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
		8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
		8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
		8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};

	logic [7:0]  ram [MEM_BYTES];
	logic [63:0] screen [SCREEN_HEIGHT];
	logic [7:0]  v [16];
	logic [11:0] ret_stack [STACK_ENTRIES];
	int          depth;
	logic [11:0] pc;
	logic [15:0] idx;
	logic [7:0]  delay_t;
	logic [7:0]  sound_t;
	logic [15:0] keys;
	logic [1:0]  fault;
	out_word_t   awaited [$];
	out_word_t   want;
	out_word_t   fresh;

	assign pc_now    = pc;
	assign depth_now = depth;

	task automatic perform(input in_word_t w, output out_word_t r);
		logic [7:0]  hi, lo, vx, vy, bits;
		logic [3:0]  x, y, n;
		logic [11:0] nnn, nxt, a;
		logic [8:0]  sum;
		logic [4:0]  row;
		logic [5:0]  col;
		bit          drew_f, wait_f, hit, flag, stop, found;
		int          i, j;
		keys   = keys | w.keys_pressed;
		drew_f = 0;
		wait_f = 0;
		if (w.action == ACT_EXEC && fault == FAULT_NONE) begin
			hi  = ram[pc];
			lo  = ram[pc + 12'd1];
			x   = hi[3:0];
			y   = lo[7:4];
			n   = lo[3:0];
			nnn = {x, lo};
			nxt = pc + 12'd2;
			stop = 0;
			if (hi[7:4] == OP_RND)
				v[x] = w.random_byte & lo;
			vx = v[x];
			vy = v[y];
			case (hi[7:4])
				OP_SYS: begin
					if (hi == 8'h00 && lo == LO_CLS) begin
						for (i = 0; i < SCREEN_HEIGHT; i++) screen[i] = '0;
					end else if (hi == 8'h00 && lo == LO_RET) begin
						if (depth == 0) begin
							fault = FAULT_UNDER;
							stop  = 1;
						end else begin
							depth--;
							nxt = ret_stack[depth];
						end
					end
				end
				OP_JP: nxt = nnn;
				OP_CALL: begin
					if (depth >= STACK_ENTRIES) begin
						fault = FAULT_OVER;
						stop  = 1;
					end else begin
						ret_stack[depth] = nxt;
						depth++;
						nxt = nnn;
					end
				end
				OP_SEQI: if (vx == lo) nxt = nxt + 12'd2;
				OP_SNEI: if (vx != lo) nxt = nxt + 12'd2;
				OP_SEQ:  if (vx == vy) nxt = nxt + 12'd2;
				OP_LDI:  v[x] = lo;
				OP_ADDI: v[x] = vx + lo;
				OP_ALU: begin
					case (n)
						ALU_MOV: v[x] = vy;
						ALU_OR:  v[x] = vx | vy;
						ALU_AND: v[x] = vx & vy;
						ALU_XOR: v[x] = vx ^ vy;
						ALU_ADD: begin
							sum   = {1'b0, vx} + {1'b0, vy};
							v[x]  = sum[7:0];
							v[15] = {7'd0, sum[8]};
						end
						ALU_SUB: begin
							flag  = vx >= vy;
							v[x]  = vx - vy;
							v[15] = {7'd0, flag};
						end
						ALU_SHR: begin
							v[x]  = vx >> 1;
							v[15] = {7'd0, vx[0]};
						end
						ALU_SUBN: begin
							flag  = vy >= vx;
							v[x]  = vy - vx;
							v[15] = {7'd0, flag};
						end
						ALU_SHL: begin
							v[x]  = vx << 1;
							v[15] = {7'd0, vx[7]};
						end
						default: ;
					endcase
				end
				OP_SNE:   if (vx != vy) nxt = nxt + 12'd2;
				OP_LDIDX: idx = {4'h0, nnn};
				OP_JPV0:  nxt = nnn + {4'h0, v[0]};
				OP_DRW: begin
					hit = 0;
					for (i = 0; i < n; i++) begin
						a    = idx[11:0] + i[11:0];
						bits = ram[a];
						row  = vy[4:0] + i[4:0];
						for (j = 0; j < 8; j++) begin
							if (bits[7-j]) begin
								col = vx[5:0] + j[5:0];
								if (screen[row][63-col]) hit = 1;
								screen[row][63-col] = ~screen[row][63-col];
							end
						end
					end
					v[15]  = {7'd0, hit};
					drew_f = 1;
				end
				OP_KEY: begin
					if (lo == LO_SKP || lo == LO_SKNP) begin
						if (keys[vx[3:0]] == (lo == LO_SKP)) nxt = nxt + 12'd2;
						keys = '0;
					end
				end
				OP_MISC: begin
					case (lo)
						LO_GDT: v[x] = delay_t;
						LO_WKEY: begin
							if (keys == 0) begin
								wait_f = 1;
								nxt    = pc;
							end else begin
								found = 0;
								for (i = 0; i < 16; i++) begin
									if (keys[i] && !found) begin
										v[x]  = i[7:0];
										found = 1;
									end
								end
							end
							keys = '0;
						end
						LO_SDT:  delay_t = vx;
						LO_SST:  sound_t = vx;
						LO_ADDI: idx = idx + {8'd0, vx};
						LO_FONT: idx = 16'(FONT_BASE) + 16'd5 * {12'd0, vx[3:0]};
						LO_BCD: begin
							ram[idx[11:0]]         = vx / 100;
							ram[idx[11:0] + 12'd1] = (vx / 10) % 10;
							ram[idx[11:0] + 12'd2] = vx % 10;
						end
						LO_STR: for (i = 0; i <= x; i++) ram[idx[11:0] + i[11:0]] = v[i];
						LO_LDR: for (i = 0; i <= x; i++) v[i] = ram[idx[11:0] + i[11:0]];
						default: ;
					endcase
				end
				default: ;
			endcase
			if (!stop) pc = nxt;
		end else if (w.action == ACT_LOAD) begin
			ram[w.load_address] = w.load_data;
		end
		r.next_pc     = pc;
		r.delay_value = delay_t;
		r.sound_value = sound_t;
		r.fault_code  = fault;
		r.waiting_key = wait_f;
		r.drew        = drew_f;
		r.row_pixels  = screen[w.row_select];
	endtask

	task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
		if (a !== e) begin
			$error("%s expected %0h got %0h", name, e, a);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MEM_BYTES; k++) ram[k] = '0;
			for (int k = 0; k < 80; k++) ram[FONT_BASE + k] = GLYPHS[k];
			for (int k = 0; k < SCREEN_HEIGHT; k++) screen[k] = '0;
			for (int k = 0; k < 16; k++) v[k] = '0;
			for (int k = 0; k < STACK_ENTRIES; k++) ret_stack[k] = '0;
			depth   = 0;
			pc      = 12'(PROGRAM_BASE);
			idx     = '0;
			delay_t = '0;
			sound_t = '0;
			keys    = '0;
			fault   = FAULT_NONE;
			awaited.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited.size() == 0) begin
					$error("result word with none expected");
					errors++;
				end else begin
					want = awaited.pop_front();
					check_field("next_pc", 64'(want.next_pc), 64'(out_data.next_pc));
					check_field("delay_value", 64'(want.delay_value),
						64'(out_data.delay_value));
					check_field("sound_value", 64'(want.sound_value),
						64'(out_data.sound_value));
					check_field("fault_code", 64'(want.fault_code), 64'(out_data.fault_code));
					check_field("waiting_key", 64'(want.waiting_key),
						64'(out_data.waiting_key));
					check_field("drew", 64'(want.drew), 64'(out_data.drew));
					check_field("row_pixels", want.row_pixels, out_data.row_pixels);
				end
			end
			if (in_valid && !in_stall) begin
				perform(in_data, fresh);
				awaited.push_back(fresh);
			end
			pending = awaited.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// testbench top: stimulus, receiver stall, time limit and verdict
module tb;

	import c8ie_pkg::*;
	import c8ie_tb_pkg::*;

	// run length and limit
	localparam int ITEMS = 1150;
	localparam int CALM_FROM = 1000;
	localparam int LIMIT = 800000;
	localparam int HOLD_AT = 300;
	localparam int HOLD_CYCLES = 300;

	localparam logic [3:0] ALU_PICK [9] = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR,
		ALU_ADD, ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL};
	localparam logic [7:0] MISC_PICK [11] = '{LO_GDT, LO_WKEY, LO_SDT, LO_SST,
		LO_ADDI, LO_FONT, LO_BCD, LO_STR, LO_LDR, LO_STR, LO_LDR};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_word_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_word_t   out_data;

	int          errors;
	int          pending;
	logic [11:0] pc_now;
	int          depth_now;

	int          sent = 0;
	int          cycles = 0;
	bit          calm = 0;
	bit          held = 0;
	int          hold_left = 0;
	int          burst = 0;

	always #2 clk = ~clk;

	chip8_instruction_execute_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	chip8_ie_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.errors   (errors),
		.pending  (pending),
		.pc_now   (pc_now),
		.depth_now(depth_now)
	);

	// receiver: short random stall bursts, one long hold-off once the
	// sender has pushed a few hundred words, nothing in the calm tail
	always @(posedge clk) begin
		if (hold_left > 0)
			hold_left--;
		else if (!held && sent >= HOLD_AT) begin
			held = 1;
			hold_left = HOLD_CYCLES;
		end else if (burst > 0)
			burst--;
		else if (!calm && $urandom_range(0, 4) == 0)
			burst = $urandom_range(1, 3);
		out_stall <= (hold_left > 0) || (burst > 0);
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// random payload around a given action; keys mostly idle so that a
	// key wait really waits, sometimes one key, sometimes a random mask
	function automatic in_word_t noise(input logic [1:0] act);
		in_word_t w;
		w.action       = act;
		w.load_address = 12'($urandom);
		w.load_data    = 8'($urandom);
		w.row_select   = 5'($urandom);
		w.random_byte  = 8'($urandom);
		case ($urandom_range(0, 7))
			0: w.keys_pressed = 16'($urandom);
			1: w.keys_pressed = 16'h1 << $urandom_range(0, 15);
			default: w.keys_pressed = '0;
		endcase
		return w;
	endfunction

	// random instruction, biased towards the defined opcodes; returns only
	// when the stack has something, calls only while it has room
	function automatic logic [15:0] pick_instr(input int depth);
		op_t        op;
		logic [3:0] x;
		logic [7:0] lo;
		int         r;
		op = op_t'($urandom_range(0, 15));
		x  = 4'($urandom);
		lo = 8'($urandom);
		r  = $urandom_range(0, 9);
		case (op)
			OP_SYS: begin
				if (r < 4) begin
					x  = 4'h0;
					lo = LO_CLS;
				end else if (r < 7) begin
					x  = 4'h0;
					lo = (depth > 0) ? LO_RET : LO_CLS;
				end else if (x == 4'h0 && lo == LO_RET && depth == 0)
					lo = 8'h00;
			end
			OP_CALL: if (depth >= STACK_ENTRIES) op = OP_JP;
			OP_ALU:  if (r < 8) lo[3:0] = ALU_PICK[$urandom_range(0, 8)];
			OP_KEY:  if (r < 8) lo = (r < 4) ? LO_SKP : LO_SKNP;
			OP_MISC: if (r < 9) lo = MISC_PICK[$urandom_range(0, 10)];
			default: ;
		endcase
		return {op, x, lo};
	endfunction

	// one word out to the block; called at a rising edge, returns at the
	// edge where the word was taken
	task automatic send_word(input in_word_t w);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_data  <= w;
		in_valid <= 1'b1;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		sent++;
	endtask

	// place an instruction at the predicted program counter, then run it;
	// the shadow pc is read at the falling edge after the last word went in
	task automatic exec_op(input bit pick, input logic [15:0] fixed);
		logic [11:0] at;
		logic [15:0] ins;
		in_word_t    w;
		in_valid <= 1'b0;
		@(negedge clk);
		at  = pc_now;
		ins = pick ? pick_instr(depth_now) : fixed;
		@(posedge clk);
		w = noise(ACT_LOAD);
		w.load_address = at;
		w.load_data    = ins[15:8];
		send_word(w);
		w = noise(ACT_LOAD);
		w.load_address = at + 12'd1;
		w.load_data    = ins[7:0];
		send_word(w);
		send_word(noise(ACT_EXEC));
	endtask

	// mix of programs and loose words: stray loads, row reads, no-ops
	task automatic random_items(input int upto);
		int r;
		while (sent < upto) begin
			r = $urandom_range(0, 39);
			if (r < 4)
				send_word(noise(ACT_LOAD));
			else if (r < 8)
				send_word(noise(ACT_READ));
			else if (r < 9)
				send_word(noise(ACT_NOP));
			else
				exec_op(1, '0);
		end
	endtask

	initial begin
		logic [15:0] directed [$];
		directed = '{
			{OP_SYS, 4'h0, LO_CLS},
			{OP_LDI, 4'h0, 8'hFF},
			{OP_ADDI, 4'h0, 8'h01},          // add wraps to zero
			{OP_LDI, 4'h1, 8'h81},
			{OP_ALU, 4'h1, 8'h1E},           // shift left, flag from bit 7
			{OP_ALU, 4'hF, 8'h14},           // flag register as target
			{OP_LDI, 4'h3, 8'd62},
			{OP_LDI, 4'h4, 8'd30},
			{OP_LDIDX, 4'hF, 8'hFE},         // sprite read wraps past top
			{OP_DRW, 4'h3, 8'h45},           // draw wraps both edges
			{OP_DRW, 4'h3, 8'h45},           // same again, collision
			{OP_DRW, 4'h3, 8'h40},           // empty sprite still draws
			{OP_LDI, 4'h0, 8'hFF},
			{OP_JPV0, 4'hF, 8'hFF},          // jump target wraps
			{OP_MISC, 4'h0, LO_FONT},
			{OP_MISC, 4'h0, LO_BCD},
			{OP_MISC, 4'h1, LO_WKEY}};

		// reset; the block then runs its own clearing pass
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening
		foreach (directed[k]) exec_op(0, directed[k]);

		// main random stretch with idling on both sides
		random_items(CALM_FROM);

		// sender pause until the pipeline has drained
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);

		// calm tail: no idling, then a stack fault halts the core
		calm = 1;
		random_items(ITEMS - 60);
		if ($urandom_range(0, 1) == 0)
			repeat (STACK_ENTRIES + 1) exec_op(0, {OP_CALL, 12'h300});
		else
			repeat (STACK_ENTRIES + 1) exec_op(0, {OP_SYS, 4'h0, LO_RET});
		// halted: execute does nothing, loads and reads still work
		random_items(ITEMS);

		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (64) @(posedge clk);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
